FILE: hw/rtl/pn3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn3_pkg
// Shared constants and types for the 3D gradient noise evaluator.
// ----------------------------------------------------------------------------
package pn3_pkg;

  localparam int unsigned TableSizeDefault = 256;
  localparam int unsigned FracBitsDefault  = 16;
  localparam int unsigned PointWidth       = 32;
  localparam int unsigned NoiseWidth       = 18;
  localparam int unsigned AddrWidth        = 9;
  localparam int unsigned DataWidth        = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_WAIT  = 7'b0000100,
    ST_FADE  = 7'b0001000,
    ST_BLEND = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

endpackage : pn3_pkg
`default_nettype wire

FILE: hw/rtl/perlin_noise_3d_eval_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perlin_noise_3d_eval_top
// Improved Perlin gradient noise in three dimensions, fixed point.
// ----------------------------------------------------------------------------
// A load transfer writes one permutation entry and gives no result. An
// evaluate transfer runs through a sequencer built around one single-port
// permutation RAM: fourteen chained reads, each an address state and then a
// registered-data state, hash the eight cube corners. The three fade curves
// are computed with one shared multiplier, four products each, and the eight
// dot products are then folded by seven interpolations on the same
// multiplier. A done state then registers the saturated result, which is
// presented in the output state until the result transfer. Only then does
// the sequencer return to idle and take the next input transfer, so an output
// stall lengthens the evaluation. The RAM has no reset; entries must be
// loaded before they are used.
// ----------------------------------------------------------------------------
module perlin_noise_3d_eval_top #(
  parameter int unsigned TableSize = pn3_pkg::TableSizeDefault,
  parameter int unsigned FracBits  = pn3_pkg::FracBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [8:0]  table_address,
  input  wire logic [7:0]  table_data,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [17:0] noise_value
);

  localparam int unsigned Depth = 2 * TableSize;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned IW    = $clog2(TableSize);
  localparam int unsigned VW    = FracBits + 5;     // working value width
  localparam int unsigned PW    = 2 * VW;           // product width
  localparam logic signed [VW-1:0] One  = VW'(1) <<< FracBits;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (FracBits - 1);

  pn3_pkg::state_t state, state_next;

  // RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  pn3_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(table_data),
    .rdata(ram_rdata)
  );

  // Point registers.
  logic [IW-1:0] xi, yi, zi;
  logic signed [VW-1:0] xf, yf, zf;
  // Hash registers: A, B, AA, AB, BA, BB and the eight corner hashes.
  logic [AW-1:0] hreg [6];
  logic [3:0]    corner [8];
  logic [3:0]    rcnt;          // read step 0..13
  logic signed [VW-1:0] fv [3]; // u, v, w
  logic signed [VW-1:0] acc [8];
  logic [1:0]    fsel;          // which coordinate is being faded
  logic [2:0]    fstep;
  logic signed [VW-1:0] ft3, fp;
  logic [2:0]    bstep;
  logic signed [17:0] res;

  // Shared multiplier with round half up to FracBits.
  logic signed [VW-1:0] ma, mb, mq;
  logic signed [PW-1:0] mprod;
  always_comb begin
    mprod = PW'(ma) * PW'(mb) + Half;
    mq    = VW'(mprod >>> FracBits);
  end

  function automatic logic signed [VW-1:0] grad(
    input logic [3:0] h, input logic signed [VW-1:0] x,
    input logic signed [VW-1:0] y, input logic signed [VW-1:0] z);
    logic signed [VW-1:0] u, v;
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) v = y;
    else if (h == 4'd12 || h == 4'd14) v = x;
    else v = z;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // Read address for each of the fourteen hash steps.
  logic [AW-1:0] rd_addr;
  always_comb begin
    case (rcnt)
      4'd0:  rd_addr = AW'(xi);
      4'd1:  rd_addr = AW'(xi) + AW'(1);
      4'd2:  rd_addr = hreg[0];
      4'd3:  rd_addr = hreg[0] + AW'(1);
      4'd4:  rd_addr = hreg[1];
      4'd5:  rd_addr = hreg[1] + AW'(1);
      4'd6:  rd_addr = hreg[2];
      4'd7:  rd_addr = hreg[2] + AW'(1);
      4'd8:  rd_addr = hreg[3];
      4'd9:  rd_addr = hreg[3] + AW'(1);
      4'd10: rd_addr = hreg[4];
      4'd11: rd_addr = hreg[4] + AW'(1);
      4'd12: rd_addr = hreg[5];
      default: rd_addr = hreg[5] + AW'(1);
    endcase
  end

  logic accept;
  assign in_stall = !(state == pn3_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_valid = (state == pn3_pkg::ST_OUT);
  assign noise_value = res;

  // Loads beyond the table are dropped.
  always_comb begin
    ram_we   = accept && (operation == pn3_pkg::OP_LOAD)
               && (32'(table_address) < Depth);
    ram_addr = accept ? AW'(table_address) : rd_addr;
  end

  // Multiplier operand selection. During blending, lo_idx names the entry
  // that holds the lower operand and also receives the interpolated value.
  logic signed [VW-1:0] fin, lo, hi;
  logic [2:0] lo_idx, hi_idx;
  always_comb begin
    fin = (fsel == 2'd0) ? xf : (fsel == 2'd1) ? yf : zf;
    lo = '0; hi = '0;
    ma = '0; mb = '0;
    lo_idx = '0; hi_idx = '0;
    if (state == pn3_pkg::ST_FADE) begin
      case (fstep)
        3'd0: begin ma = fin; mb = VW'(6 * fin - 15 * One); end
        3'd1: begin ma = fin; mb = fin; end
        3'd2: begin ma = ft3; mb = fin; end
        default: begin ma = ft3; mb = fp; end
      endcase
    end else begin
      case (bstep) inside
        [3'd0:3'd3]: begin
          lo_idx = {bstep[1:0], 1'b0}; hi_idx = {bstep[1:0], 1'b1}; ma = fv[0];
        end
        3'd4, 3'd5: begin
          lo_idx = {bstep[0], 2'b00}; hi_idx = {bstep[0], 2'b10}; ma = fv[1];
        end
        default: begin lo_idx = 3'd0; hi_idx = 3'd4; ma = fv[2]; end
      endcase
      lo = acc[lo_idx];
      hi = acc[hi_idx];
      mb = hi - lo;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pn3_pkg::ST_IDLE:
        if (accept && operation == pn3_pkg::OP_EVAL) state_next = pn3_pkg::ST_READ;
      pn3_pkg::ST_READ:  state_next = pn3_pkg::ST_WAIT;
      pn3_pkg::ST_WAIT:
        state_next = (rcnt == 4'd13) ? pn3_pkg::ST_FADE : pn3_pkg::ST_READ;
      pn3_pkg::ST_FADE:
        if (fsel == 2'd2 && fstep == 3'd3) state_next = pn3_pkg::ST_BLEND;
      pn3_pkg::ST_BLEND:
        if (bstep == 3'd6) state_next = pn3_pkg::ST_DONE;
      pn3_pkg::ST_DONE:  state_next = pn3_pkg::ST_OUT;
      pn3_pkg::ST_OUT:
        if (!out_stall) state_next = pn3_pkg::ST_IDLE;
      default: state_next = pn3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pn3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic signed [VW-1:0] fc;
  always_comb begin
    fc = mq;
    if (fc < 0) fc = '0;
    if (fc > One) fc = One;
  end

  always_ff @(posedge clk) begin
    case (state)
      pn3_pkg::ST_IDLE: begin
        xi <= point_x[FracBits +: IW];
        yi <= point_y[FracBits +: IW];
        zi <= point_z[FracBits +: IW];
        xf <= VW'({1'b0, point_x[FracBits-1:0]});
        yf <= VW'({1'b0, point_y[FracBits-1:0]});
        zf <= VW'({1'b0, point_z[FracBits-1:0]});
        rcnt <= '0; fsel <= '0; fstep <= '0; bstep <= '0;
      end
      pn3_pkg::ST_WAIT: begin
        rcnt <= rcnt + 4'd1;
        case (rcnt)
          4'd0: hreg[0] <= AW'(ram_rdata) + AW'(yi);
          4'd1: hreg[1] <= AW'(ram_rdata) + AW'(yi);
          4'd2: hreg[2] <= AW'(ram_rdata) + AW'(zi);
          4'd3: hreg[3] <= AW'(ram_rdata) + AW'(zi);
          4'd4: hreg[4] <= AW'(ram_rdata) + AW'(zi);
          4'd5: hreg[5] <= AW'(ram_rdata) + AW'(zi);
          4'd6:  corner[0] <= ram_rdata[3:0];  // AA
          4'd7:  corner[4] <= ram_rdata[3:0];  // AA+1
          4'd8:  corner[2] <= ram_rdata[3:0];  // AB
          4'd9:  corner[6] <= ram_rdata[3:0];  // AB+1
          4'd10: corner[1] <= ram_rdata[3:0];  // BA
          4'd11: corner[5] <= ram_rdata[3:0];  // BA+1
          4'd12: corner[3] <= ram_rdata[3:0];  // BB
          default: corner[7] <= ram_rdata[3:0]; // BB+1
        endcase
      end
      pn3_pkg::ST_FADE: begin
        case (fstep)
          3'd0: fp <= VW'(mq + 10 * One);
          3'd1: ft3 <= mq;
          3'd2: ft3 <= mq;
          default: fv[fsel] <= fc;
        endcase
        if (fstep == 3'd3) begin
          fstep <= '0; fsel <= fsel + 2'd1;
        end else begin
          fstep <= fstep + 3'd1;
        end
        for (int i = 0; i < 8; i++) begin
          acc[i] <= grad(corner[i], i[0] ? xf - One : xf,
                         i[1] ? yf - One : yf, i[2] ? zf - One : zf);
        end
      end
      pn3_pkg::ST_BLEND: begin
        bstep <= bstep + 3'd1;
        acc[lo_idx] <= lo + mq;
      end
      pn3_pkg::ST_DONE: begin
        if (acc[0] > VW'(131071)) res <= 18'sd131071;
        else if (acc[0] < -VW'(131072)) res <= -18'sd131072;
        else res <= acc[0][17:0];
      end
      default: ;
    endcase
  end

endmodule : perlin_noise_3d_eval_top
`default_nettype wire

FILE: hw/rtl/pn3_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn3_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pn3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : pn3_ram
`default_nettype wire

FILE: hw/rtl/pn3_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn3_assertions
// Port-level checks for the noise evaluator.
// ----------------------------------------------------------------------------
module pn3_assertions (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [17:0] noise_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(noise_value))
    else $error("result changed while stalled");

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result presented right after an input transfer");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule : pn3_assertions

bind perlin_noise_3d_eval_top pn3_assertions u_pn3_assertions (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
);
`default_nettype wire

FILE: bench/pn3_checker.sv
// ----------------------------------------------------------------------------
// pn3_checker
// Watches both channels of the 3D noise evaluator and compares its results.
// ----------------------------------------------------------------------------
// It keeps its own copy of the permutation table and computes the noise value
// of each evaluate transfer. Every output transfer is checked against the
// oldest noise value still waiting.
// ----------------------------------------------------------------------------
module pn3_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               operation,
  input  wire logic [8:0]         table_address,
  input  wire logic [7:0]         table_data,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [17:0] noise_value,
  output int                      failures,
  output int                      pending
);

  localparam int Frac = 16;
  localparam longint One = 64'sd1 <<< Frac;

  logic [7:0] perm_copy [512];
  logic signed [17:0] noise_queue [$];

  function automatic longint fix_mul(longint a, longint b);
    // Round half up, then floor.
    return (a * b + (One >>> 1)) >>> Frac;
  endfunction

  function automatic longint fade_q(longint t);
    longint p, t3, f;
    p = fix_mul(t, 6 * t - 15 * One) + 10 * One;
    t3 = fix_mul(fix_mul(t, t), t);
    f = fix_mul(t3, p);
    if (f < 0) f = 0;
    if (f > One) f = One;
    return f;
  endfunction

  function automatic longint lerp_q(longint t, longint a, longint b);
    return a + fix_mul(t, b - a);
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    if (h < 4) v = y;
    else if (h == 12 || h == 14) v = x;
    else v = z;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] perm_at(int unsigned i);
    return perm_copy[i & 511];
  endfunction

  function automatic logic signed [17:0] noise_at(logic [31:0] px, logic [31:0] py,
                                                  logic [31:0] pz);
    int unsigned cx, cy, cz, a, b, aa, ab, ba, bb;
    longint x, y, z, u, v, w, r;
    cx = px[23:16];
    cy = py[23:16];
    cz = pz[23:16];
    x = px[15:0];
    y = py[15:0];
    z = pz[15:0];
    u = fade_q(x);
    v = fade_q(y);
    w = fade_q(z);
    a  = perm_at(cx) + cy;
    aa = perm_at(a) + cz;
    ab = perm_at(a + 1) + cz;
    b  = perm_at(cx + 1) + cy;
    ba = perm_at(b) + cz;
    bb = perm_at(b + 1) + cz;
    r = lerp_q(w,
          lerp_q(v,
            lerp_q(u, corner_dot(perm_at(aa), x, y, z),
                      corner_dot(perm_at(ba), x - One, y, z)),
            lerp_q(u, corner_dot(perm_at(ab), x, y - One, z),
                      corner_dot(perm_at(bb), x - One, y - One, z))),
          lerp_q(v,
            lerp_q(u, corner_dot(perm_at(aa + 1), x, y, z - One),
                      corner_dot(perm_at(ba + 1), x - One, y, z - One)),
            lerp_q(u, corner_dot(perm_at(ab + 1), x, y - One, z - One),
                      corner_dot(perm_at(bb + 1), x - One, y - One, z - One))));
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  // The pending count is registered, so it reflects the transfers of the
  // previous edge when the stimulus looks at it after the next one.
  always @(posedge clk) begin
    logic signed [17:0] want;
    if (rst) begin
      failures <= 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (operation == pn3_pkg::OP_LOAD) perm_copy[table_address] <= table_data;
        else noise_queue.push_back(noise_at(point_x, point_y, point_z));
      end
      if (out_valid && !out_stall) begin
        if (noise_queue.size() == 0) begin
          $display("%0t: unexpected noise_value %0d", $time, noise_value);
          failures <= failures + 1;
        end else begin
          want = noise_queue.pop_front();
          if (noise_value !== want) begin
            $display("%0t: noise_value expected %0d actual %0d", $time, want, noise_value);
            failures <= failures + 1;
          end
        end
      end
      pending <= noise_queue.size();
    end
  end

endmodule : pn3_checker

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 3D gradient noise evaluator.
// ----------------------------------------------------------------------------
// The whole permutation table is loaded first, then a directed set of points
// and a long random mix of evaluations and table reloads runs, with random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit = 1000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               operation = pn3_pkg::OP_LOAD;
  logic [8:0]         table_address = '0;
  logic [7:0]         table_data = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [17:0] noise_value;

  int failures;
  int pending;
  int cycles = 0;
  int stall_hold = 0;
  // When set, neither side idles, so the sender leaves no gaps and the output is never stalled.
  bit calm = 1'b0;

  perlin_noise_3d_eval_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .table_address(table_address), .table_data(table_data),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
  );

  pn3_checker noise_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .table_address(table_address), .table_data(table_data),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value),
    .failures(failures), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // The output side runs in stretches, each stalled or open at random.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold <= idle_len();
    end
  end

  // Presents one item and returns at the edge where the transfer happens or,
  // when a gap follows, after the gap. The valid stays high into a back-to-back
  // item, so it is only lowered when a gap follows.
  task automatic send(logic op, logic [8:0] addr, logic [7:0] data,
                      logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    operation <= op;
    table_address <= addr;
    table_data <= data;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_entry(int unsigned addr, logic [7:0] data);
    send(pn3_pkg::OP_LOAD, addr[8:0], data, $urandom, $urandom, $urandom);
  endtask

  task automatic eval_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send(pn3_pkg::OP_EVAL, 9'($urandom), 8'($urandom), px, py, pz);
  endtask

  // Coordinates that favor the edges of the fraction and cells near the origin.
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 5))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hFFFF;
      2: c[31:16] = 16'($urandom_range(0, 3));
      default: ;
    endcase
    return c;
  endfunction

  // The first edge lets the last input transfer reach the pending count.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // The sequencer returns to idle at the same edge at which the last result leaves.
    repeat (60) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every entry gets written before the first evaluation reads any of them.
    calm = 1'b1;
    for (int i = 0; i < 512; i++) load_entry(i, 8'($urandom));
    calm = 1'b0;

    // Directed part: the data extremes at the address extremes, then points
    // at the corners of the coordinate range and of the cell.
    load_entry(0, 8'h00);
    load_entry(511, 8'hFF);
    eval_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    eval_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    eval_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    eval_point(32'h0001_0000, 32'h00FF_0000, 32'hFFFF_0000);
    eval_point(32'h00FF_FFFF, 32'h0000_0001, 32'h8000_FFFF);
    eval_point(32'h0000_FFFF, 32'h7FFF_0000, 32'h0000_4000);
    eval_point(32'hFFFF_8000, 32'h0000_C000, 32'h00FE_2000);
    eval_point(32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_F0F0);
    wait_drained();

    // Random part: mostly evaluations, with table reloads mixed in. Halfway
    // the sender holds off until every noise value is back.
    for (int n = 0; n < 450; n++) begin
      if (n % 100 == 50) calm = 1'b1;
      if (n % 100 == 70) calm = 1'b0;
      if (n == 225) wait_drained();
      if ($urandom_range(0, 4) == 0) load_entry($urandom_range(0, 511), 8'($urandom));
      else eval_point(rand_coord(), rand_coord(), rand_coord());
    end
    in_valid <= 1'b0;

    wait_drained();
    if (failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule : tb_top

FILE: perlin_noise_3d_eval_top.f
hw/rtl/pn3_pkg.sv
hw/rtl/pn3_ram.sv
hw/rtl/perlin_noise_3d_eval_top.sv
hw/rtl/pn3_checker.sv
bench/pn3_checker.sv
bench/tb_top.sv
